/* sv/tmnq_pkg.sv */
// Shared types and codes for the triangle mesh neighbor query block.
// No dependencies; imported by the top module and the distance unit, not by the table storage.
package tmnq_pkg;

    // Operation carried in s_tuser
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_QUERY  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Fixed port field widths
    localparam int unsigned PORT_ID_W    = 16;
    localparam int unsigned PORT_COORD_W = 16;
    localparam int unsigned INDEX_W      = 10;
    localparam int unsigned OUT_IDS      = 3;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_CORNER,
        ST_SQY,
        ST_PLACE,
        ST_CHK_RD,
        ST_CHK_EVAL
    } state_t;

    // Control of the shared square-accumulate unit
    typedef struct packed {
        logic en;
        logic clear;
    } sq_ctl_t;

endpackage

/* sv/triangle_mesh_neighbor_query.sv */
// Triangle table with insert, clear, edge lookup and nearest-neighbor query.
// Insert, clear, and lookup or query on an empty table: result in the cycle after the transfer.
// Lookup reads and checks each stored triangle in turn. Query reads each triangle, measures
// the corners of a triangle holding the query id, and rechecks the earlier triangles for a
// corner of triangle i that would enter the list.
// Not ready until the result transfer. Reset clears the count; table stays undefined.
module triangle_mesh_neighbor_query #(
    parameter int MAX_TRIANGLES  = 1024,
    parameter int ID_BITS        = 16,
    parameter int COORD_BITS     = 16,
    parameter int KEPT_NEIGHBORS = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_id, first_x, first_y, second_id, second_x, second_y,
    // third_id, third_x, third_y
    input  logic [143:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, triangle_index, neighbor_count, nearest_id, second_nearest_id,
    // third_nearest_id, zero pad
    output logic [63:0]  m_tdata
);
    import tmnq_pkg::*;

    localparam int AW    = $clog2(MAX_TRIANGLES);
    localparam int CW    = $clog2(MAX_TRIANGLES + 1);
    localparam int IDB   = ID_BITS;
    localparam int C     = COORD_BITS;
    localparam int DW    = 2 * COORD_BITS + 3;
    localparam int ROW_W = 3 * IDB + 6 * C;
    localparam int K     = KEPT_NEIGHBORS;
    localparam int KW    = $clog2(KEPT_NEIGHBORS + 1);
    localparam int NOUT  = (KEPT_NEIGHBORS < 3) ? KEPT_NEIGHBORS : 3;

    // Control registers
    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   chk_reg, chk_next;
    logic [1:0]      corner_reg, corner_next;
    logic [KW-1:0]   kept_reg, kept_next;
    logic            out_valid_reg, out_valid_next;
    op_t             op_reg, op_next;

    // Payload registers
    logic [IDB-1:0]  q_id_reg, q_id_next;
    logic [IDB-1:0]  b_id_reg, b_id_next;
    logic [C-1:0]    q_x_reg, q_x_next;
    logic [C-1:0]    q_y_reg, q_y_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [KW-1:0]   pos_reg, pos_next;
    logic [IDB-1:0]  top_id_reg [K];
    logic [IDB-1:0]  top_id_next [K];
    logic [DW-1:0]   top_d_reg [K];
    logic [DW-1:0]   top_d_next [K];
    logic [1:0]      out_status_reg, out_status_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [1:0]      out_count_reg, out_count_next;
    logic [PORT_ID_W-1:0] out_id_reg [OUT_IDS];
    logic [PORT_ID_W-1:0] out_id_next [OUT_IDS];

    // Table and distance unit wiring
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [ROW_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [ROW_W-1:0] mem_rdata;
    sq_ctl_t          sq_ctl;
    logic [C-1:0]     sq_a;
    logic [C-1:0]     sq_b;
    logic [DW-1:0]    sq_acc;

    // Input fields, masked and extended to internal widths
    logic [IDB-1:0]   in_id [3];
    logic [C-1:0]     in_x [3];
    logic [C-1:0]     in_y [3];
    logic [31:0]      ext_id [3];
    logic [31:0]      ext_x [3];
    logic [31:0]      ext_y [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ext_id[c] = {16'b0, s_tdata[48*c +: 16]};
            ext_x[c]  = {{16{s_tdata[48*c+31]}}, s_tdata[48*c+16 +: 16]};
            ext_y[c]  = {{16{s_tdata[48*c+47]}}, s_tdata[48*c+32 +: 16]};
            in_id[c]  = ext_id[c][IDB-1:0];
            in_x[c]   = ext_x[c][C-1:0];
            in_y[c]   = ext_y[c][C-1:0];
        end
    end

    tmnq_mem #(
        .DEPTH  (MAX_TRIANGLES),
        .ADDR_W (AW),
        .DATA_W (ROW_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tmnq_sqacc #(
        .COORD_BITS (C)
    ) u_sqacc (
        .clk (clk),
        .ctl (sq_ctl),
        .a   (sq_a),
        .b   (sq_b),
        .acc (sq_acc)
    );

    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b0, out_id_reg[2], out_id_reg[1], out_id_reg[0],
                        out_count_reg, out_index_reg, out_status_reg};
    assign mem_raddr = (state_reg == ST_CHK_RD) ? chk_reg[AW-1:0] : idx_reg[AW-1:0];

    // Sequencer: next state, table access, list update and result
    always_comb
    begin
        logic [IDB-1:0] r_id [3];
        logic [IDB-1:0] c_id [3];
        logic [C-1:0]   c_x [3];
        logic [C-1:0]   c_y [3];
        logic [IDB-1:0] v_id;
        logic           hit;
        logic           has_v;
        logic           match;
        logic           skip;
        logic           next_corner;
        logic           do_insert;
        logic           advance;
        logic           finish;
        logic [KW-1:0]  pos;
        logic [31:0]    wide;

        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        chk_next       = chk_reg;
        corner_next    = corner_reg;
        kept_next      = kept_reg;
        op_next        = op_reg;
        q_id_next      = q_id_reg;
        b_id_next      = b_id_reg;
        q_x_next       = q_x_reg;
        q_y_next       = q_y_reg;
        row_next       = row_reg;
        pos_next       = pos_reg;
        top_id_next    = top_id_reg;
        top_d_next     = top_d_reg;
        out_status_next = out_status_reg;
        out_index_next = out_index_reg;
        out_count_next = out_count_reg;
        out_id_next    = out_id_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = {in_y[2], in_x[2], in_y[1], in_x[1], in_y[0], in_x[0],
                          in_id[2], in_id[1], in_id[0]};
        sq_ctl         = '0;
        next_corner    = 1'b0;
        do_insert      = 1'b0;
        advance        = 1'b0;
        finish         = 1'b0;
        skip           = 1'b0;
        match          = 1'b0;
        hit            = 1'b0;
        has_v          = 1'b0;
        pos            = '0;
        wide           = '0;

        for (int c = 0; c < 3; c++)
        begin
            r_id[c] = mem_rdata[c*IDB +: IDB];
            c_id[c] = row_reg[c*IDB +: IDB];
            c_x[c]  = row_reg[3*IDB + 2*c*C +: C];
            c_y[c]  = row_reg[3*IDB + (2*c+1)*C +: C];
        end

        unique case (corner_reg)
            2'd0:    v_id = c_id[0];
            2'd1:    v_id = c_id[1];
            2'd2:    v_id = c_id[2];
            default: v_id = c_id[0];
        endcase
        unique case (corner_reg)
            2'd0:    sq_a = c_x[0];
            2'd1:    sq_a = c_x[1];
            2'd2:    sq_a = c_x[2];
            default: sq_a = c_x[0];
        endcase
        sq_b = q_x_reg;
        if (state_reg == ST_SQY)
        begin
            unique case (corner_reg)
                2'd0:    sq_a = c_y[0];
                2'd1:    sq_a = c_y[1];
                2'd2:    sq_a = c_y[2];
                default: sq_a = c_y[0];
            endcase
            sq_b = q_y_reg;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    op_next        = op_t'(s_tuser);
                    q_id_next      = in_id[0];
                    q_x_next       = in_x[0];
                    q_y_next       = in_y[0];
                    b_id_next      = in_id[1];
                    idx_next       = '0;
                    chk_next       = '0;
                    kept_next      = '0;
                    out_status_next = STATUS_OK;
                    out_index_next = '0;
                    out_count_next = '0;
                    for (int j = 0; j < OUT_IDS; j++)
                    begin
                        out_id_next[j] = '0;
                    end
                    unique case (op_t'(s_tuser))
                        OP_INSERT:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == CW'(MAX_TRIANGLES))
                            begin
                                out_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                wide           = 32'(count_reg);
                                out_index_next = wide[INDEX_W-1:0];
                                count_next     = count_reg + CW'(1);
                            end
                        end
                        OP_LOOKUP, OP_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                                if (op_t'(s_tuser) == OP_LOOKUP)
                                begin
                                    out_status_next = STATUS_NOT_FOUND;
                                end
                            end
                            else
                            begin
                                state_next = ST_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        for (int d = 0; d < 3; d++)
                        begin
                            if (c != d && r_id[c] == q_id_reg && r_id[d] == b_id_reg)
                            begin
                                match = 1'b1;
                            end
                        end
                    end
                    if (match)
                    begin
                        wide           = 32'(idx_reg);
                        out_index_next = wide[INDEX_W-1:0];
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else if (idx_reg + CW'(1) == count_reg)
                    begin
                        out_status_next = STATUS_NOT_FOUND;
                        out_valid_next  = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        if (r_id[c] == q_id_reg)
                        begin
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                    begin
                        row_next    = mem_rdata;
                        corner_next = 2'd0;
                        state_next  = ST_CORNER;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
            end

            ST_CORNER:
            begin
                // Skip the query id, repeats inside the row and ids already kept
                skip = (v_id == q_id_reg);
                if (corner_reg != 2'd0 && v_id == c_id[0])
                begin
                    skip = 1'b1;
                end
                if (corner_reg == 2'd2 && v_id == c_id[1])
                begin
                    skip = 1'b1;
                end
                for (int k = 0; k < K; k++)
                begin
                    if (KW'(k) < kept_reg && top_id_reg[k] == v_id)
                    begin
                        skip = 1'b1;
                    end
                end
                if (skip)
                begin
                    next_corner = 1'b1;
                end
                else
                begin
                    sq_ctl.en    = 1'b1;
                    sq_ctl.clear = 1'b1;
                    state_next   = ST_SQY;
                end
            end

            ST_SQY:
            begin
                sq_ctl.en  = 1'b1;
                state_next = ST_PLACE;
            end

            ST_PLACE:
            begin
                // Stable place: after every kept entry at or below the distance
                for (int k = 0; k < K; k++)
                begin
                    if (KW'(k) < kept_reg && top_d_reg[k] <= sq_acc)
                    begin
                        pos = pos + KW'(1);
                    end
                end
                pos_next = pos;
                if (pos >= KW'(K))
                begin
                    next_corner = 1'b1;
                end
                else if (idx_reg == '0)
                begin
                    do_insert   = 1'b1;
                    next_corner = 1'b1;
                end
                else
                begin
                    chk_next   = '0;
                    state_next = ST_CHK_RD;
                end
            end

            ST_CHK_RD:
            begin
                state_next = ST_CHK_EVAL;
            end

            ST_CHK_EVAL:
            begin
                // An earlier triangle with both ids already offered this one
                pos = pos_reg;
                for (int c = 0; c < 3; c++)
                begin
                    if (r_id[c] == q_id_reg)
                    begin
                        hit = 1'b1;
                    end
                    if (r_id[c] == v_id)
                    begin
                        has_v = 1'b1;
                    end
                end
                if (hit && has_v)
                begin
                    next_corner = 1'b1;
                end
                else if (chk_reg + CW'(1) == idx_reg)
                begin
                    do_insert   = 1'b1;
                    next_corner = 1'b1;
                end
                else
                begin
                    chk_next   = chk_reg + CW'(1);
                    state_next = ST_CHK_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Insert the candidate into the sorted list
        if (do_insert)
        begin
            for (int k = K - 1; k >= 1; k--)
            begin
                if (KW'(k) > pos)
                begin
                    top_id_next[k] = top_id_reg[k-1];
                    top_d_next[k]  = top_d_reg[k-1];
                end
            end
            for (int k = 0; k < K; k++)
            begin
                if (KW'(k) == pos)
                begin
                    top_id_next[k] = v_id;
                    top_d_next[k]  = sq_acc;
                end
            end
            if (kept_reg < KW'(K))
            begin
                kept_next = kept_reg + KW'(1);
            end
        end

        // Step to the next corner or the next triangle
        if (next_corner)
        begin
            if (corner_reg == 2'd2)
            begin
                advance = 1'b1;
            end
            else
            begin
                corner_next = corner_reg + 2'd1;
                state_next  = ST_CORNER;
            end
        end
        if (advance)
        begin
            if (idx_reg + CW'(1) == count_reg)
            begin
                finish = 1'b1;
            end
            else
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = ST_RD;
            end
        end

        // Query result from the list as it stands after this cycle
        if (finish)
        begin
            wide           = 32'(kept_next);
            out_count_next = wide[1:0];
            for (int j = 0; j < NOUT; j++)
            begin
                wide = 32'(top_id_next[j]);
                out_id_next[j] = (KW'(j) < kept_next) ? wide[PORT_ID_W-1:0] : '0;
            end
            out_valid_next = 1'b1;
            state_next     = ST_IDLE;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            chk_reg       <= '0;
            corner_reg    <= '0;
            kept_reg      <= '0;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_INSERT;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            corner_reg    <= corner_next;
            kept_reg      <= kept_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        q_id_reg       <= q_id_next;
        b_id_reg       <= b_id_next;
        q_x_reg        <= q_x_next;
        q_y_reg        <= q_y_next;
        row_reg        <= row_next;
        pos_reg        <= pos_next;
        top_id_reg     <= top_id_next;
        top_d_reg      <= top_d_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_count_reg  <= out_count_next;
        out_id_reg     <= out_id_next;
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TRIANGLES))
        else $error("triangle count above table depth");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KW'(K))
        else $error("kept neighbor count above list size");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser == OP_CLEAR) |=> (count_reg == '0 && m_tvalid))
        else $error("clear did not empty the table");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (idx_reg < count_reg && chk_reg <= idx_reg))
        else $error("scan index outside stored triangles");

endmodule

/* sv/tmnq_mem.sv */
// Triangle table storage: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
module tmnq_mem #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 144
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

/* sv/tmnq_sqacc.sv */
// Shared distance unit: squares |a - b| and adds it into an accumulator.
// Depends on tmnq_pkg for the control struct.
module tmnq_sqacc #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  tmnq_pkg::sq_ctl_t           ctl,
    input  logic signed [COORD_BITS-1:0] a,
    input  logic signed [COORD_BITS-1:0] b,
    output logic [2*COORD_BITS+2:0]     acc
);
    import tmnq_pkg::*;

    localparam int DW = 2 * COORD_BITS + 3;

    logic signed [COORD_BITS:0]   diff;
    logic [COORD_BITS:0]          mag;
    logic [2*COORD_BITS+1:0]      sq;
    logic [DW-1:0]                acc_reg;

    // Magnitude of the difference and its square
    always_comb
    begin
        diff = (COORD_BITS+1)'(a) - (COORD_BITS+1)'(b);
        mag  = diff[COORD_BITS] ? (COORD_BITS+1)'(-diff) : (COORD_BITS+1)'(diff);
        sq   = (2*COORD_BITS+2)'(mag) * (2*COORD_BITS+2)'(mag);
    end

    // Accumulate, restarting from zero on clear
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= (ctl.clear ? DW'(0) : acc_reg) + DW'(sq);
        end
    end

    assign acc = acc_reg;

endmodule
